FILE: design/gqi_pkg.sv
// Shared types, constants and the Hamilton product term table for the integrator.
package gqi_pkg;

  localparam int unsigned DataW = 32;
  localparam int unsigned WideW = 64;

  localparam logic signed [DataW-1:0] OneQ30 = 32'sh4000_0000;
  localparam logic [WideW-1:0] OneQ53 = 64'h0020_0000_0000_0000;
  localparam logic signed [DataW-1:0] SatMax = 32'sh7FFF_FFFF;
  localparam logic signed [DataW-1:0] SatMin = 32'sh8000_0000;

  // Datapath operations issued by the controller
  typedef enum logic [3:0] {
    OP_NONE,
    OP_CAPTURE,
    OP_DELTA,
    OP_LOAD,
    OP_SHIFT,
    OP_SQ_MUL,
    OP_SQ_ACC,
    OP_SQRT_INIT,
    OP_SQRT_STEP,
    OP_DIV_INIT,
    OP_DIV_STEP,
    OP_DIV_STORE,
    OP_PR_MUL,
    OP_PR_ACC,
    OP_ROUND,
    OP_OUT
  } op_e;

  typedef struct packed {
    op_e        op;
    logic       sel;   // 0: stored pose, 1: delta
    logic [1:0] idx;
    logic [1:0] term;
  } cmd_t;

  typedef struct packed {
    logic big;  // some magnitude still needs a right shift
  } sts_t;

  typedef struct packed {
    logic [1:0] ai;
    logic [1:0] bi;
    logic       neg;
  } ham_t;

  // One term of the Hamilton product a * b for result part r
  function automatic ham_t ham_term(input logic [1:0] r, input logic [1:0] t);
    ham_t h;
    unique case ({r, t})
      4'h0: h = '{ai: 2'd3, bi: 2'd0, neg: 1'b0};
      4'h1: h = '{ai: 2'd0, bi: 2'd3, neg: 1'b0};
      4'h2: h = '{ai: 2'd1, bi: 2'd2, neg: 1'b0};
      4'h3: h = '{ai: 2'd2, bi: 2'd1, neg: 1'b1};
      4'h4: h = '{ai: 2'd3, bi: 2'd1, neg: 1'b0};
      4'h5: h = '{ai: 2'd1, bi: 2'd3, neg: 1'b0};
      4'h6: h = '{ai: 2'd2, bi: 2'd0, neg: 1'b0};
      4'h7: h = '{ai: 2'd0, bi: 2'd2, neg: 1'b1};
      4'h8: h = '{ai: 2'd3, bi: 2'd2, neg: 1'b0};
      4'h9: h = '{ai: 2'd2, bi: 2'd3, neg: 1'b0};
      4'hA: h = '{ai: 2'd0, bi: 2'd1, neg: 1'b0};
      4'hB: h = '{ai: 2'd1, bi: 2'd0, neg: 1'b1};
      4'hC: h = '{ai: 2'd3, bi: 2'd3, neg: 1'b0};
      4'hD: h = '{ai: 2'd0, bi: 2'd0, neg: 1'b1};
      4'hE: h = '{ai: 2'd1, bi: 2'd1, neg: 1'b1};
      default: h = '{ai: 2'd2, bi: 2'd2, neg: 1'b1};
    endcase
    return h;
  endfunction

endpackage

FILE: design/gqi_in_if.sv
// Input channel: gyro rates and time step.
interface gqi_in_if;
  import gqi_pkg::*;
  logic                    valid;
  logic                    ready;
  logic signed [DataW-1:0] rate_x;
  logic signed [DataW-1:0] rate_y;
  logic signed [DataW-1:0] rate_z;
  logic [DataW-1:0]        interval;

  modport source (output valid, rate_x, rate_y, rate_z, interval, input ready);
  modport sink (input valid, rate_x, rate_y, rate_z, interval, output ready);
endinterface

FILE: design/gqi_out_if.sv
// Output channel: updated orientation quaternion.
interface gqi_out_if;
  import gqi_pkg::*;
  logic                    valid;
  logic                    ready;
  logic signed [DataW-1:0] pose_x;
  logic signed [DataW-1:0] pose_y;
  logic signed [DataW-1:0] pose_z;
  logic signed [DataW-1:0] pose_w;

  modport source (output valid, pose_x, pose_y, pose_z, pose_w, input ready);
  modport sink (input valid, pose_x, pose_y, pose_z, pose_w, output ready);
endinterface

FILE: design/gqi_dp.sv
// Datapath: delta forming, normalization (shift, squares, sqrt, divide) and product.
module gqi_dp (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  gqi_pkg::cmd_t                  cmd_i,
  output gqi_pkg::sts_t                  sts_o,
  input  logic signed [gqi_pkg::DataW-1:0] rate_x_i,
  input  logic signed [gqi_pkg::DataW-1:0] rate_y_i,
  input  logic signed [gqi_pkg::DataW-1:0] rate_z_i,
  input  logic [gqi_pkg::DataW-1:0]        interval_i,
  output logic signed [gqi_pkg::DataW-1:0] pose_x_o,
  output logic signed [gqi_pkg::DataW-1:0] pose_y_o,
  output logic signed [gqi_pkg::DataW-1:0] pose_z_o,
  output logic signed [gqi_pkg::DataW-1:0] pose_w_o
);
  import gqi_pkg::*;

  logic signed [DataW-1:0] rate_q [3];
  logic [DataW-1:0]        ivl_q;
  logic signed [WideW-1:0] dlt_q [3];
  logic [WideW-1:0]        mag_q [4];
  logic [3:0]              neg_q;
  logic [61:0]             sq_q;
  logic [WideW-1:0]        sum_q;
  logic [WideW-1:0]        n_q, r_q, bit_q;
  logic [DataW-1:0]        rem_q, dq_q;
  logic signed [DataW-1:0] a_q [4];
  logic signed [DataW-1:0] b_q [4];
  logic signed [WideW-1:0] prod_q, pacc_q;
  logic signed [DataW-1:0] ori_q [4];
  logic signed [DataW-1:0] pose_q [4];

  logic signed [DataW:0]   ivl_s;
  logic signed [64:0]      dmul;
  logic [WideW-1:0]        src [4];
  logic [WideW-1:0]        rb;
  logic [WideW-1:0]        num;
  logic [DataW:0]          dtry;
  logic                    dge;
  logic signed [DataW-1:0] qval;
  ham_t                    ht;
  logic signed [WideW-1:0] rnd;
  logic signed [DataW-1:0] sat;
  logic                    big;

  // Delta multiply: signed rate times unsigned step
  assign ivl_s = {1'b0, ivl_q};
  assign dmul  = rate_q[cmd_i.idx] * ivl_s;

  // Operand source for the normalizer
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      src[i] = cmd_i.sel ? dlt_q[i] : WideW'(ori_q[i]);
    end
    src[3] = cmd_i.sel ? OneQ53 : WideW'(ori_q[3]);
  end

  // Shift needed while any magnitude reaches 2^31
  always_comb begin
    big = 1'b0;
    for (int i = 0; i < 4; i++) big = big | (|mag_q[i][WideW-1:31]);
  end
  assign sts_o.big = big;

  // Square-root step and divide step
  assign rb   = r_q + bit_q;
  assign num  = (mag_q[cmd_i.idx] << 30) + (r_q >> 1);
  assign dtry = {rem_q, dq_q[DataW-1]};
  assign dge  = dtry >= {1'b0, r_q[DataW-1:0]};

  // Normalized part, identity for a zero-length quaternion
  always_comb begin
    if (r_q == '0) begin
      qval = (cmd_i.idx == 2'd3) ? OneQ30 : '0;
    end else begin
      qval = neg_q[cmd_i.idx] ? -$signed(dq_q) : $signed(dq_q);
    end
  end

  // Product term selection and rounding with saturation
  assign ht  = ham_term(cmd_i.idx, cmd_i.term);
  assign rnd = (pacc_q + 64'sd536870912) >>> 30;
  always_comb begin
    if (rnd > WideW'(SatMax)) begin
      sat = SatMax;
    end else if (rnd < WideW'(SatMin)) begin
      sat = SatMin;
    end else begin
      sat = rnd[DataW-1:0];
    end
  end

  // Orientation state, reset to identity
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ori_q[0] <= '0;
      ori_q[1] <= '0;
      ori_q[2] <= '0;
      ori_q[3] <= OneQ30;
    end else if (cmd_i.op == OP_ROUND) begin
      ori_q[cmd_i.idx] <= sat;
    end
  end

  // Working registers
  always_ff @(posedge clk_i) begin
    unique case (cmd_i.op)
      OP_CAPTURE: begin
        rate_q[0] <= rate_x_i;
        rate_q[1] <= rate_y_i;
        rate_q[2] <= rate_z_i;
        ivl_q     <= interval_i;
      end
      OP_DELTA: dlt_q[cmd_i.idx] <= dmul[WideW-1:0];
      OP_LOAD: begin
        for (int i = 0; i < 4; i++) begin
          neg_q[i] <= src[i][WideW-1];
          mag_q[i] <= src[i][WideW-1] ? -src[i] : src[i];
        end
      end
      OP_SHIFT: begin
        for (int i = 0; i < 4; i++) mag_q[i] <= mag_q[i] >> 1;
      end
      OP_SQ_MUL: sq_q <= mag_q[cmd_i.idx][30:0] * mag_q[cmd_i.idx][30:0];
      OP_SQ_ACC: sum_q <= ((cmd_i.idx == 2'd0) ? '0 : sum_q) + WideW'(sq_q);
      OP_SQRT_INIT: begin
        n_q   <= sum_q;
        r_q   <= '0;
        bit_q <= 64'h4000_0000_0000_0000;
      end
      OP_SQRT_STEP: begin
        if (n_q >= rb) begin
          n_q <= n_q - rb;
          r_q <= (r_q >> 1) + bit_q;
        end else begin
          r_q <= r_q >> 1;
        end
        bit_q <= bit_q >> 2;
      end
      OP_DIV_INIT: begin
        rem_q <= num[WideW-1:DataW];
        dq_q  <= num[DataW-1:0];
      end
      OP_DIV_STEP: begin
        rem_q <= dge ? DataW'(dtry - {1'b0, r_q[DataW-1:0]}) : dtry[DataW-1:0];
        dq_q  <= {dq_q[DataW-2:0], dge};
      end
      OP_DIV_STORE: begin
        if (cmd_i.sel) b_q[cmd_i.idx] <= qval;
        else a_q[cmd_i.idx] <= qval;
      end
      OP_PR_MUL: prod_q <= a_q[ht.ai] * b_q[ht.bi];
      OP_PR_ACC: pacc_q <= ((cmd_i.term == 2'd0) ? '0 : pacc_q)
                           + (ht.neg ? -prod_q : prod_q);
      OP_OUT: begin
        for (int i = 0; i < 4; i++) pose_q[i] <= ori_q[i];
      end
      default: ;
    endcase
  end

  assign pose_x_o = pose_q[0];
  assign pose_y_o = pose_q[1];
  assign pose_z_o = pose_q[2];
  assign pose_w_o = pose_q[3];

endmodule

FILE: design/gqi_ctrl.sv
// Controller: sequences the datapath through one update per item.
module gqi_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  input  gqi_pkg::sts_t sts_i,
  output gqi_pkg::cmd_t cmd_o
);
  import gqi_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_DELTA, S_LOAD, S_SHIFT, S_SQ_MUL, S_SQ_ACC, S_SQRT_INIT, S_SQRT,
    S_DIV_INIT, S_DIV, S_DIV_STORE, S_PR_MUL, S_PR_ACC, S_ROUND, S_OUT
  } state_e;

  state_e     state_q;
  logic       sel_q;
  logic [1:0] idx_q, term_q;
  logic [4:0] step_q;
  logic       out_valid_q;
  logic       out_load;

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_load    = (state_q == S_OUT) && (!out_valid_q || out_ready_i);

  // Command decode
  always_comb begin
    cmd_o.sel  = sel_q;
    cmd_o.idx  = idx_q;
    cmd_o.term = term_q;
    unique case (state_q)
      S_IDLE:      cmd_o.op = in_valid_i ? OP_CAPTURE : OP_NONE;
      S_DELTA:     cmd_o.op = OP_DELTA;
      S_LOAD:      cmd_o.op = OP_LOAD;
      S_SHIFT:     cmd_o.op = sts_i.big ? OP_SHIFT : OP_NONE;
      S_SQ_MUL:    cmd_o.op = OP_SQ_MUL;
      S_SQ_ACC:    cmd_o.op = OP_SQ_ACC;
      S_SQRT_INIT: cmd_o.op = OP_SQRT_INIT;
      S_SQRT:      cmd_o.op = OP_SQRT_STEP;
      S_DIV_INIT:  cmd_o.op = OP_DIV_INIT;
      S_DIV:       cmd_o.op = OP_DIV_STEP;
      S_DIV_STORE: cmd_o.op = OP_DIV_STORE;
      S_PR_MUL:    cmd_o.op = OP_PR_MUL;
      S_PR_ACC:    cmd_o.op = OP_PR_ACC;
      S_ROUND:     cmd_o.op = OP_ROUND;
      S_OUT:       cmd_o.op = out_load ? OP_OUT : OP_NONE;
      default:     cmd_o.op = OP_NONE;
    endcase
  end

  // Sequencer state and output valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      sel_q       <= 1'b0;
      idx_q       <= '0;
      term_q      <= '0;
      step_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (out_load) out_valid_q <= 1'b1;
      else if (out_ready_i) out_valid_q <= 1'b0;

      unique case (state_q)
        S_IDLE: begin
          if (in_valid_i) begin
            idx_q   <= '0;
            state_q <= S_DELTA;
          end
        end
        S_DELTA: begin
          if (idx_q == 2'd2) begin
            sel_q   <= 1'b0;
            state_q <= S_LOAD;
          end else begin
            idx_q <= idx_q + 2'd1;
          end
        end
        S_LOAD: state_q <= S_SHIFT;
        S_SHIFT: begin
          if (!sts_i.big) begin
            idx_q   <= '0;
            state_q <= S_SQ_MUL;
          end
        end
        S_SQ_MUL: state_q <= S_SQ_ACC;
        S_SQ_ACC: begin
          if (idx_q == 2'd3) begin
            state_q <= S_SQRT_INIT;
          end else begin
            idx_q   <= idx_q + 2'd1;
            state_q <= S_SQ_MUL;
          end
        end
        S_SQRT_INIT: begin
          step_q  <= '0;
          state_q <= S_SQRT;
        end
        S_SQRT: begin
          step_q <= step_q + 5'd1;
          if (step_q == 5'd31) begin
            idx_q   <= '0;
            state_q <= S_DIV_INIT;
          end
        end
        S_DIV_INIT: begin
          step_q  <= '0;
          state_q <= S_DIV;
        end
        S_DIV: begin
          step_q <= step_q + 5'd1;
          if (step_q == 5'd31) state_q <= S_DIV_STORE;
        end
        S_DIV_STORE: begin
          if (idx_q != 2'd3) begin
            idx_q   <= idx_q + 2'd1;
            state_q <= S_DIV_INIT;
          end else if (!sel_q) begin
            sel_q   <= 1'b1;
            state_q <= S_LOAD;
          end else begin
            idx_q   <= '0;
            term_q  <= '0;
            state_q <= S_PR_MUL;
          end
        end
        S_PR_MUL: state_q <= S_PR_ACC;
        S_PR_ACC: begin
          if (term_q == 2'd3) begin
            state_q <= S_ROUND;
          end else begin
            term_q  <= term_q + 2'd1;
            state_q <= S_PR_MUL;
          end
        end
        S_ROUND: begin
          term_q <= '0;
          if (idx_q == 2'd3) begin
            state_q <= S_OUT;
          end else begin
            idx_q   <= idx_q + 2'd1;
            state_q <= S_PR_MUL;
          end
        end
        S_OUT: begin
          if (out_load) state_q <= S_IDLE;
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

endmodule

FILE: design/gyro_quaternion_integrator_core.sv
// The normalizing right shifts of the stored pose, s1 (0..1), and of the delta, s2 (23..32),
// lengthen the time from input accept to result valid.
// One item is processed at a time on the single shared datapath, which runs a bit-serial
// square root (32 steps) and four 32-step divisions per quaternion.
// The next item is taken while a finished result waits in the output register.
// Reset (async, active low): pose returns to identity, controller idle, no result valid.
module gyro_quaternion_integrator_core (
  input  logic clk_i,
  input  logic rst_ni,
  gqi_in_if.sink    in_i,
  gqi_out_if.source out_o
);
  import gqi_pkg::*;

  cmd_t cmd;
  sts_t sts;

  gqi_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_ready_o  (in_i.ready),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  gqi_dp u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .sts_o      (sts),
    .rate_x_i   (in_i.rate_x),
    .rate_y_i   (in_i.rate_y),
    .rate_z_i   (in_i.rate_z),
    .interval_i (in_i.interval),
    .pose_x_o   (out_o.pose_x),
    .pose_y_o   (out_o.pose_y),
    .pose_z_o   (out_o.pose_z),
    .pose_w_o   (out_o.pose_w)
  );

`ifndef SYNTH
  // Only one item at a time in the datapath
  a_one_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_i.valid && in_i.ready |=> !in_i.ready)
    else $error("second item accepted while busy");

  // Normalizer shifts only while a magnitude is too wide
  a_shift_needed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.op == OP_SHIFT |-> sts.big)
    else $error("shift issued without need");

  // Loading the output register raises valid
  a_out_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.op == OP_OUT |=> out_o.valid)
    else $error("result loaded but not valid");
`endif

endmodule

FILE: sim/tb_top.sv
// Testbench for the gyro quaternion integrator: directed table, random items, predictor check.
`timescale 1ns / 100ps
module tb_top;
  import gqi_pkg::*;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  gqi_in_if in_ch ();
  gqi_out_if out_ch ();

  gyro_quaternion_integrator_core i_dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_ch),
    .out_o (out_ch)
  );

  typedef struct packed {
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic signed [31:0] z;
    logic signed [31:0] w;
  } quat_t;

  typedef struct {
    logic signed [31:0] rx;
    logic signed [31:0] ry;
    logic signed [31:0] rz;
    logic [31:0]        dt;
    bit                 known;
    quat_t              pose;
  } gyro_row_t;

  quat_t pose_q[$];
  quat_t tracked_pose;
  int    n_errors = 0;
  bit    drain_wait = 1'b0;
  bit    long_hold = 1'b0;
  bit    quiet_phase = 1'b0;

  // Clock: 12 ns period
  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // Floor square root of a 64-bit value
  function automatic logic [63:0] isqrt(input logic [63:0] n);
    logic [63:0] r, b;
    r = 64'd0;
    b = 64'd1 << 62;
    while (b > n) b = b >> 2;
    while (b != 0) begin
      if (n >= r + b) begin
        n = n - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  // Scale four signed parts to unit length in Q2.30
  function automatic void unit_quat(input logic signed [63:0] c[4],
                                    output logic signed [63:0] q[4]);
    logic [63:0] mag[4];
    bit          neg[4];
    logic [63:0] peak, acc, len, v;
    int          s;
    peak = 0;
    acc = 0;
    s = 0;
    for (int i = 0; i < 4; i++) begin
      neg[i] = c[i] < 0;
      mag[i] = neg[i] ? 64'd0 - c[i] : c[i];
      if (mag[i] > peak) peak = mag[i];
    end
    while (s < 63 && (peak >> s) >= 64'h8000_0000) s++;
    for (int i = 0; i < 4; i++) begin
      mag[i] = mag[i] >> s;
      acc += mag[i] * mag[i];
    end
    len = isqrt(acc);
    if (len == 0) begin
      q[0] = 0; q[1] = 0; q[2] = 0; q[3] = 64'sd1 << 30;
      return;
    end
    for (int i = 0; i < 4; i++) begin
      v = ((mag[i] << 30) + (len >> 1)) / len;
      q[i] = neg[i] ? -$signed(v) : $signed(v);
    end
  endfunction

  // Round Q4.60 to Q2.30 and saturate
  function automatic logic signed [31:0] round_q30(input logic signed [63:0] v);
    logic signed [63:0] r;
    r = (v + (64'sd1 <<< 29)) >>> 30;
    if (r > 64'sd2147483647) return SatMax;
    if (r < -64'sd2147483648) return SatMin;
    return r[31:0];
  endfunction

  // Advance the tracked pose by one gyro sample
  function automatic quat_t integrate_pose(input logic signed [31:0] rx, ry, rz,
                                           input logic [31:0] dt);
    logic signed [63:0] c[4], d[4], a[4], b[4], r[4];
    logic signed [63:0] dts;
    quat_t p;
    dts = $signed({32'd0, dt});
    c[0] = tracked_pose.x; c[1] = tracked_pose.y;
    c[2] = tracked_pose.z; c[3] = tracked_pose.w;
    d[0] = rx * dts; d[1] = ry * dts; d[2] = rz * dts;
    d[3] = $signed(OneQ53);
    unit_quat(c, a);
    unit_quat(d, b);
    r[0] = a[3]*b[0] + a[0]*b[3] + a[1]*b[2] - a[2]*b[1];
    r[1] = a[3]*b[1] + a[1]*b[3] + a[2]*b[0] - a[0]*b[2];
    r[2] = a[3]*b[2] + a[2]*b[3] + a[0]*b[1] - a[1]*b[0];
    r[3] = a[3]*b[3] - a[0]*b[0] - a[1]*b[1] - a[2]*b[2];
    p.x = round_q30(r[0]); p.y = round_q30(r[1]);
    p.z = round_q30(r[2]); p.w = round_q30(r[3]);
    tracked_pose = p;
    return p;
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got, exp_v);
    $display("mismatch %s: got %h expected %h at %0t", what, got, exp_v, $realtime);
    n_errors++;
  endtask

  // Send one item; predicted pose is queued at acceptance
  task automatic send_item(input logic signed [31:0] rx, ry, rz, input logic [31:0] dt,
                           input bit known, input quat_t kpose);
    quat_t p;
    in_ch.rate_x <= rx;
    in_ch.rate_y <= ry;
    in_ch.rate_z <= rz;
    in_ch.interval <= dt;
    in_ch.valid <= 1'b1;
    do @(posedge clk_i); while (!in_ch.ready);
    p = integrate_pose(rx, ry, rz, dt);
    if (known && p != kpose) begin
      $display("table row disagrees with predictor");
      n_errors++;
    end
    pose_q.push_back(p);
    @(negedge clk_i);
    // Valid stays up into the next item unless the sender idles
    if (!quiet_phase && $urandom_range(99) < 17) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(negedge clk_i);
    end
  endtask

  function automatic logic [31:0] rand_field();
    case ($urandom_range(5))
      0: return 32'h7FFF_FFFF;
      1: return 32'h8000_0000;
      2: return $urandom_range(0, 4095) - 2048;
      3: return 32'hFFFF_FFFF;
      default: return $urandom;
    endcase
  endfunction

  // Output side: ready with random stalls, one long hold-off
  initial begin
    out_ch.ready = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (long_hold) begin
        out_ch.ready <= 1'b0;
        repeat (3000) @(negedge clk_i);
        long_hold = 1'b0;
      end
      out_ch.ready <= quiet_phase ? 1'b1 : ($urandom_range(99) >= 17);
    end
  end

  // Result checker
  always @(posedge clk_i) begin
    quat_t e;
    if (rst_ni && out_ch.valid && out_ch.ready) begin
      if (pose_q.size() == 0) begin
        $display("unexpected result at %0t", $realtime);
        n_errors++;
      end else begin
        e = pose_q.pop_front();
        if (out_ch.pose_x !== e.x) report_mismatch("pose_x", out_ch.pose_x, e.x);
        if (out_ch.pose_y !== e.y) report_mismatch("pose_y", out_ch.pose_y, e.y);
        if (out_ch.pose_z !== e.z) report_mismatch("pose_z", out_ch.pose_z, e.z);
        if (out_ch.pose_w !== e.w) report_mismatch("pose_w", out_ch.pose_w, e.w);
      end
    end
  end

  // Stimulus
  initial begin
    gyro_row_t rows[$];
    gyro_row_t row;
    int k;
    in_ch.valid = 1'b0;
    in_ch.rate_x = '0;
    in_ch.rate_y = '0;
    in_ch.rate_z = '0;
    in_ch.interval = '0;
    tracked_pose = '{x: 0, y: 0, z: 0, w: OneQ30};
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Zero rate or zero step keeps the identity
    rows.push_back('{0, 0, 0, 0, 1'b1, '{0, 0, 0, OneQ30}});
    rows.push_back('{32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh7FFF_FFFF, 0, 1'b1,
                     '{0, 0, 0, OneQ30}});
    rows.push_back('{0, 0, 0, 32'hFFFF_FFFF, 1'b1, '{0, 0, 0, OneQ30}});
    // Huge delta on a single axis: close to a half turn about that axis; then all-axis and mixed rows
    rows.push_back('{32'sh7FFF_FFFF, 0, 0, 32'hFFFF_FFFF, 1'b0, '{0, 0, 0, 0}});
    rows.push_back('{32'sh8000_0000, 0, 0, 32'hFFFF_FFFF, 1'b0, '{0, 0, 0, 0}});
    rows.push_back('{0, 32'sh7FFF_FFFF, 0, 32'hFFFF_FFFF, 1'b0, '{0, 0, 0, 0}});
    rows.push_back('{0, 0, 32'sh8000_0000, 32'hFFFF_FFFF, 1'b0, '{0, 0, 0, 0}});
    rows.push_back('{32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000, 32'hFFFF_FFFF,
                     1'b0, '{0, 0, 0, 0}});
    rows.push_back('{32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'h8000_0000,
                     1'b0, '{0, 0, 0, 0}});
    rows.push_back('{1, -1, 1, 1, 1'b0, '{0, 0, 0, 0}});
    rows.push_back('{32'sh0010_0000, 32'sh0020_0000, -32'sh0030_0000, 32'h0041_8937,
                     1'b0, '{0, 0, 0, 0}});
    rows.push_back('{-1, -1, -1, 32'hFFFF_FFFF, 1'b0, '{0, 0, 0, 0}});
    rows.push_back('{32'h5555_5555, 32'hAAAA_AAAA, 32'h0F0F_0F0F, 32'hAAAA_AAAA, 1'b0,
                     '{0, 0, 0, 0}});
    foreach (rows[i]) send_item(rows[i].rx, rows[i].ry, rows[i].rz, rows[i].dt,
                                rows[i].known, rows[i].pose);

    // Random part, with a quiet stretch, a long output hold-off and a drain pause
    for (k = 0; k < 1200; k++) begin
      quiet_phase = (k >= 300 && k < 450);
      if (k == 600) long_hold = 1'b1;
      if (k == 900) begin
        in_ch.valid <= 1'b0;
        wait (pose_q.size() == 0);
        @(negedge clk_i);
      end
      if ($urandom_range(3) == 0)
        send_item(rand_field(), rand_field(), rand_field(), rand_field(), 1'b0, '0);
      else
        send_item($urandom_range(0, 32'h00A0_0000) - 32'sh0050_0000,
                  $urandom_range(0, 32'h00A0_0000) - 32'sh0050_0000,
                  $urandom_range(0, 32'h00A0_0000) - 32'sh0050_0000,
                  $urandom_range(0, 32'h0100_0000), 1'b0, '0);
    end

    in_ch.valid <= 1'b0;
    wait (pose_q.size() == 0);
    repeat (500) @(posedge clk_i);
    if (n_errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  // Run limit
  initial begin
    #50ms;
    $display("TEST FAILED");
    $finish;
  end

endmodule
